[hdl/perm_fs_pkg.sv]
package perm_fs_pkg;

   localparam int PROC_W           = 16;
   localparam int CFG_W            = 6;
   localparam int OUT_TIME_W       = 32;
   localparam int FLOW_W           = 40;
   localparam int DEF_MAX_MACHINES = 32;
   localparam int DEF_TIME_BITS    = 32;
   localparam int POS_W_MAX        = 8;
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [CFG_W-1:0]  NUM_MACHINES_RESET = CFG_W'(1);
   localparam logic [FLOW_W-1:0] FLOW_MAX           = '1;

   typedef struct packed {
      logic [PROC_W-1:0]    proc_time;
      logic [POS_W_MAX-1:0] pos;
      logic                 job_end;
      logic                 last;
   } op_type;

endpackage

[hdl/perm_fs_ram.sv]
module perm_fs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/perm_fs_queue.sv]
module perm_fs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  perm_fs_pkg::op_type push_data,
   output logic                pop_valid,
   input  logic                pop,
   output perm_fs_pkg::op_type pop_data
);

   import perm_fs_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   op_type          mem_ff [QUEUE_DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign push_ready = (count_ff != CW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/perm_fs_front.sv]
module perm_fs_front #(
   parameter int MAX_MACHINES = perm_fs_pkg::DEF_MAX_MACHINES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [perm_fs_pkg::CFG_W-1:0]   csr_num_machines,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [perm_fs_pkg::PROC_W-1:0]  req_proc_time,
   input  logic                            req_last_job,
   output logic                            push_valid,
   input  logic                            push_ready,
   output perm_fs_pkg::op_type             push_data
);

   import perm_fs_pkg::*;

   localparam int PW = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
   localparam int MW = $clog2(MAX_MACHINES + 1);
   localparam int NW = (MW > CFG_W) ? MW : CFG_W;

   logic [CFG_W-1:0] nm_ff, nm_in;
   logic [PW-1:0]    pos_ff, pos_in;
   logic [MW-1:0]    eff_m;
   logic [MW-1:0]    pos_inc;
   logic             job_end;
   logic             accept;

   assign csr_ready  = 1'b1;
   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   always_comb begin
      if (nm_ff == '0) begin
         eff_m = MW'(1);
      end else if (NW'(nm_ff) > NW'(MAX_MACHINES)) begin
         eff_m = MW'(MAX_MACHINES);
      end else begin
         eff_m = MW'(nm_ff);
      end
   end

   assign pos_inc = MW'(pos_ff) + MW'(1);
   assign job_end = (pos_inc >= eff_m);

   always_comb begin
      push_data.proc_time = req_proc_time;
      push_data.pos       = POS_W_MAX'(pos_ff);
      push_data.job_end   = job_end;
      push_data.last      = job_end && req_last_job;
   end

   always_comb begin
      nm_in  = (csr_valid && csr_ready) ? csr_num_machines : nm_ff;
      pos_in = pos_ff;
      if (accept) begin
         pos_in = job_end ? '0 : PW'(pos_inc);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nm_ff  <= NUM_MACHINES_RESET;
         pos_ff <= '0;
      end else begin
         nm_ff  <= nm_in;
         pos_ff <= pos_in;
      end
   end

endmodule

[hdl/perm_fs_back.sv]
module perm_fs_back #(
   parameter int MAX_MACHINES = perm_fs_pkg::DEF_MAX_MACHINES,
   parameter int TIME_BITS    = perm_fs_pkg::DEF_TIME_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   output logic                                q_pop,
   input  perm_fs_pkg::op_type                 q_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [perm_fs_pkg::OUT_TIME_W-1:0]  rsp_job_completion,
   output logic [perm_fs_pkg::OUT_TIME_W-1:0]  rsp_makespan,
   output logic [perm_fs_pkg::FLOW_W-1:0]      rsp_flowtime,
   output logic                                rsp_sequence_done
);

   import perm_fs_pkg::*;

   localparam int PW = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
   localparam int SW = (TIME_BITS > FLOW_W) ? TIME_BITS + 1 : FLOW_W + 1;

   logic [PW-1:0]           a_addr;
   logic                    hit;

   op_type                  b_op_ff;
   logic                    b_valid_ff, b_valid_in;
   logic                    b_zero_ff;
   logic                    b_byp_ff;
   logic [TIME_BITS-1:0]    b_byp_data_ff;
   logic [PW-1:0]           b_addr;
   logic [TIME_BITS-1:0]    ram_rd_data;
   logic [TIME_BITS-1:0]    start_mem;
   logic [TIME_BITS-1:0]    start_val;
   logic [TIME_BITS:0]      done_sum;
   logic [TIME_BITS-1:0]    done_val;
   logic [TIME_BITS-1:0]    run_new;
   logic                    b_fire;
   logic                    b_wr;
   logic                    b_clear;
   logic [TIME_BITS-1:0]    job_run_ff, job_run_in;
   logic [MAX_MACHINES-1:0] vld_ff, vld_in;

   logic                    c_valid_ff, c_valid_in;
   logic [TIME_BITS-1:0]    c_cj_ff;
   logic                    c_last_ff;
   logic                    c_ready;
   logic                    c_fire;
   logic                    out_free;
   logic [TIME_BITS-1:0]    max_ff, max_in;
   logic [FLOW_W-1:0]       sum_ff, sum_in;
   logic [TIME_BITS-1:0]    max_new;
   logic [SW-1:0]           sum_wide;
   logic [FLOW_W-1:0]       sum_new;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OUT_TIME_W-1:0]   rsp_cj_ff;
   logic [OUT_TIME_W-1:0]   rsp_span_ff;
   logic [FLOW_W-1:0]       rsp_flow_ff;
   logic                    rsp_done_ff;

   // issue: pop an operation and read the machine's ready time
   assign a_addr = q_data.pos[PW-1:0];
   assign q_pop  = q_valid && (!b_valid_ff || b_fire);
   assign hit    = b_wr && (b_addr == a_addr);

   perm_fs_ram #(
      .WIDTH(TIME_BITS),
      .DEPTH(MAX_MACHINES)
   ) u_ready_ram (
      .clock  (clock),
      .wr_en  (b_wr),
      .wr_addr(b_addr),
      .wr_data(done_val),
      .rd_en  (q_pop),
      .rd_addr(a_addr),
      .rd_data(ram_rd_data)
   );

   // execute: start at the later of machine and job, saturate the finish
   assign b_addr    = b_op_ff.pos[PW-1:0];
   assign start_mem = b_zero_ff ? '0 : (b_byp_ff ? b_byp_data_ff : ram_rd_data);
   assign start_val = (job_run_ff > start_mem) ? job_run_ff : start_mem;
   assign done_sum  = {1'b0, start_val} + (TIME_BITS + 1)'(b_op_ff.proc_time);
   assign done_val  = done_sum[TIME_BITS] ? '1 : done_sum[TIME_BITS-1:0];
   assign run_new   = (b_op_ff.proc_time != '0) ? done_val : job_run_ff;

   assign b_fire  = b_valid_ff && (!b_op_ff.job_end || c_ready);
   assign b_wr    = b_fire && (b_op_ff.proc_time != '0);
   assign b_clear = b_fire && b_op_ff.last;

   always_comb begin
      b_valid_in = b_valid_ff;
      if (q_pop) begin
         b_valid_in = 1'b1;
      end else if (b_fire) begin
         b_valid_in = 1'b0;
      end

      job_run_in = job_run_ff;
      if (b_fire) begin
         job_run_in = b_op_ff.job_end ? '0 : run_new;
      end

      vld_in = vld_ff;
      if (b_clear) begin
         vld_in = '0;
      end else if (b_wr) begin
         vld_in[b_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         job_run_ff <= '0;
         vld_ff     <= '0;
      end else begin
         b_valid_ff <= b_valid_in;
         job_run_ff <= job_run_in;
         vld_ff     <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         b_op_ff       <= q_data;
         b_zero_ff     <= b_clear || (!hit && !vld_ff[a_addr]);
         b_byp_ff      <= !b_clear && hit;
         b_byp_data_ff <= done_val;
      end
   end

   // statistics and result register
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign c_fire   = c_valid_ff && out_free;
   assign c_ready  = !c_valid_ff || c_fire;

   assign max_new  = (c_cj_ff > max_ff) ? c_cj_ff : max_ff;
   assign sum_wide = SW'(sum_ff) + SW'(c_cj_ff);
   assign sum_new  = (sum_wide > SW'(FLOW_MAX)) ? FLOW_MAX : sum_wide[FLOW_W-1:0];

   always_comb begin
      c_valid_in = c_valid_ff;
      if (b_fire && b_op_ff.job_end) begin
         c_valid_in = 1'b1;
      end else if (c_fire) begin
         c_valid_in = 1'b0;
      end

      max_in = max_ff;
      sum_in = sum_ff;
      if (c_fire) begin
         max_in = c_last_ff ? '0 : max_new;
         sum_in = c_last_ff ? '0 : sum_new;
      end

      rsp_valid_in = rsp_valid_ff;
      if (c_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff   <= 1'b0;
         max_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         c_valid_ff   <= c_valid_in;
         max_ff       <= max_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_fire && b_op_ff.job_end) begin
         c_cj_ff   <= run_new;
         c_last_ff <= b_op_ff.last;
      end
      if (c_fire) begin
         rsp_cj_ff   <= OUT_TIME_W'(c_cj_ff);
         rsp_span_ff <= OUT_TIME_W'(max_new);
         rsp_flow_ff <= sum_new;
         rsp_done_ff <= c_last_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_job_completion = rsp_cj_ff;
   assign rsp_makespan       = rsp_span_ff;
   assign rsp_flowtime       = rsp_flow_ff;
   assign rsp_sequence_done  = rsp_done_ff;

endmodule

[hdl/perm_flowshop_makespan_flowtime_core.sv]
// A job's last operation passes the queue, execute and statistics registers to the result.
// Throughput: one operation per cycle unless stalled; one ready-time read and write each.
// A stalled result holds the back at the next job's last operation; the front keeps accepting
// until the two-entry queue fills.
// Reset (synchronous, active high) sets the machine count to 1 and clears all job and sequence
// state; machine ready times read as zero through per-machine valid bits, so no clearing pass.
module perm_flowshop_makespan_flowtime_core #(
   parameter int MAX_MACHINES = perm_fs_pkg::DEF_MAX_MACHINES,
   parameter int TIME_BITS    = perm_fs_pkg::DEF_TIME_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [perm_fs_pkg::CFG_W-1:0]       csr_num_machines,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [perm_fs_pkg::PROC_W-1:0]      req_proc_time,
   input  logic                                req_last_job,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [perm_fs_pkg::OUT_TIME_W-1:0]  rsp_job_completion,
   output logic [perm_fs_pkg::OUT_TIME_W-1:0]  rsp_makespan,
   output logic [perm_fs_pkg::FLOW_W-1:0]      rsp_flowtime,
   output logic                                rsp_sequence_done
);

   import perm_fs_pkg::*;

   logic   push_valid;
   logic   push_ready;
   op_type push_data;
   logic   q_valid;
   logic   q_pop;
   op_type q_data;

   perm_fs_front #(
      .MAX_MACHINES(MAX_MACHINES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_num_machines(csr_num_machines),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_proc_time   (req_proc_time),
      .req_last_job    (req_last_job),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_data       (push_data)
   );

   perm_fs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_data),
      .pop_valid (q_valid),
      .pop       (q_pop),
      .pop_data  (q_data)
   );

   perm_fs_back #(
      .MAX_MACHINES(MAX_MACHINES),
      .TIME_BITS   (TIME_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_pop             (q_pop),
      .q_data            (q_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_job_completion(rsp_job_completion),
      .rsp_makespan      (rsp_makespan),
      .rsp_flowtime      (rsp_flowtime),
      .rsp_sequence_done (rsp_sequence_done)
   );

endmodule

[hdl/perm_fs_checker.sv]
module perm_fs_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [perm_fs_pkg::OUT_TIME_W-1:0]  rsp_job_completion,
   input logic [perm_fs_pkg::OUT_TIME_W-1:0]  rsp_makespan,
   input logic [perm_fs_pkg::FLOW_W-1:0]      rsp_flowtime,
   input logic                                rsp_sequence_done
);

   import perm_fs_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_job_completion) &&
         $stable(rsp_makespan) && $stable(rsp_flowtime) && $stable(rsp_sequence_done))
      else $error("result changed before its transfer");

   a_span_covers_job: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_makespan >= rsp_job_completion)
      else $error("makespan below job completion");

   a_flow_covers_job: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_flowtime >= FLOW_W'(rsp_job_completion))
      else $error("flowtime below job completion");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind perm_flowshop_makespan_flowtime_core perm_fs_checker u_checker (.*);

[verif/perm_flowshop_makespan_flowtime_core_test.sv]
module perm_flowshop_makespan_flowtime_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import perm_fs_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS = 110;
   localparam int PHASE_COUNT = 11;
   localparam int LONG_SEQ_ITEMS = 60;

   typedef struct packed {
      logic [OUT_TIME_W-1:0] completion;
      logic [OUT_TIME_W-1:0] makespan;
      logic [FLOW_W-1:0]     flowtime;
      logic                  done;
   } job_result_type;

   class sequence_tracker_type;
      logic [CFG_W-1:0]      machines;
      logic [OUT_TIME_W-1:0] machine_ready [DEF_MAX_MACHINES];
      logic [OUT_TIME_W-1:0] job_running;
      int unsigned           machine_pos;
      logic [OUT_TIME_W-1:0] max_completion;
      logic [FLOW_W-1:0]     completion_sum;
      job_result_type        due_jobs [$];
      int                    errors;

      function new();
         machines = NUM_MACHINES_RESET;
         errors = 0;
         clear_sequence();
      endfunction

      function void clear_sequence();
         foreach (machine_ready[k]) machine_ready[k] = '0;
         job_running = '0;
         machine_pos = 0;
         max_completion = '0;
         completion_sum = '0;
      endfunction

      function void set_machine_count(logic [CFG_W-1:0] value);
         machines = value;
      endfunction

      function int pending();
         return due_jobs.size();
      endfunction

      function void add_operation(logic [PROC_W-1:0] proc, logic last);
         int unsigned           span;
         int unsigned           pos;
         logic [OUT_TIME_W-1:0] start;
         logic [OUT_TIME_W:0]   finish;
         logic [FLOW_W:0]       total;
         job_result_type        job;
         span = (machines == 0) ? 1 :
                (machines > DEF_MAX_MACHINES) ? DEF_MAX_MACHINES : machines;
         pos = (machine_pos >= DEF_MAX_MACHINES) ? DEF_MAX_MACHINES - 1 : machine_pos;
         if (proc != 0) begin
            start = (job_running > machine_ready[pos]) ? job_running : machine_ready[pos];
            finish = {1'b0, start} + proc;
            if (finish[OUT_TIME_W]) finish = {1'b0, {OUT_TIME_W{1'b1}}};
            machine_ready[pos] = finish[OUT_TIME_W-1:0];
            job_running = finish[OUT_TIME_W-1:0];
         end
         if (pos + 1 < span) begin
            machine_pos = pos + 1;
            return;
         end
         if (job_running > max_completion) max_completion = job_running;
         total = {1'b0, completion_sum} + job_running;
         completion_sum = total[FLOW_W] ? FLOW_MAX : total[FLOW_W-1:0];
         job.completion = job_running;
         job.makespan = max_completion;
         job.flowtime = completion_sum;
         job.done = last;
         due_jobs.insert(due_jobs.size(), job);
         if (last) begin
            clear_sequence();
         end else begin
            job_running = '0;
            machine_pos = 0;
         end
      endfunction

      function void check_job(job_result_type got);
         job_result_type want;
         if (due_jobs.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: completion %0d makespan %0d flowtime %0d done %0b",
                        got.completion, got.makespan, got.flowtime, got.done);
            return;
         end
         want = due_jobs.pop_front();
         if (got.completion !== want.completion || got.makespan !== want.makespan ||
             got.flowtime !== want.flowtime || got.done !== want.done) begin
            errors++;
            if (errors <= 10) begin
               $display("result mismatch: expected completion %0d makespan %0d flowtime %0d done %0b",
                        want.completion, want.makespan, want.flowtime, want.done);
               $display("                 actual   completion %0d makespan %0d flowtime %0d done %0b",
                        got.completion, got.makespan, got.flowtime, got.done);
            end
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CFG_W-1:0]      csr_num_machines = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [PROC_W-1:0]     req_proc_time = '0;
   logic                  req_last_job = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [OUT_TIME_W-1:0] rsp_job_completion;
   logic [OUT_TIME_W-1:0] rsp_makespan;
   logic [FLOW_W-1:0]     rsp_flowtime;
   logic                  rsp_sequence_done;

   sequence_tracker_type jobs = new();
   int                   burst_left = 0;
   int                   ready_mode = 0;
   int                   ready_hold = 0;
   int                   idle_cycles = 0;

   perm_flowshop_makespan_flowtime_core dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_num_machines   (csr_num_machines),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_proc_time      (req_proc_time),
      .req_last_job       (req_last_job),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_job_completion (rsp_job_completion),
      .rsp_makespan       (rsp_makespan),
      .rsp_flowtime       (rsp_flowtime),
      .rsp_sequence_done  (rsp_sequence_done)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (ready_hold == 0) begin
         ready_mode <= int'($urandom_range(0, 3));
         ready_hold <= int'($urandom_range(20, 200));
      end else begin
         ready_hold <= ready_hold - 1;
      end
      case (ready_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= ~rsp_ready;
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         jobs.check_job({rsp_job_completion, rsp_makespan, rsp_flowtime, rsp_sequence_done});
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_operation(input logic [PROC_W-1:0] proc, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_proc_time <= proc;
      req_last_job <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      jobs.add_operation(proc, last);
   endtask

   // hold the sender until every result has gone, then let the pipeline settle
   task automatic drain();
      req_valid <= 1'b0;
      while (jobs.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_machines(input logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_num_machines <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      jobs.set_machine_count(value);
   endtask

   initial begin
      logic [CFG_W-1:0]  setting;
      logic [PROC_W-1:0] proc;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_operation('0, 1'b0);
      send_operation('1, 1'b0);
      send_operation(PROC_W'(1), 1'b1);
      drain();
      write_machines('0);
      send_operation(PROC_W'(7), 1'b1);
      send_operation('0, 1'b0);
      drain();
      write_machines(CFG_W'(3));
      send_operation(PROC_W'(5), 1'b1);
      send_operation('0, 1'b0);
      send_operation(PROC_W'(7), 1'b0);
      send_operation('0, 1'b1);
      send_operation('0, 1'b0);
      send_operation('0, 1'b1);
      drain();
      write_machines(CFG_W'(5));
      send_operation(PROC_W'(3), 1'b0);
      send_operation('1, 1'b0);
      send_operation(PROC_W'(2), 1'b0);
      drain();
      write_machines(CFG_W'(2));
      send_operation(PROC_W'(4), 1'b1);
      drain();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: setting = '1;
            1: setting = CFG_W'(DEF_MAX_MACHINES);
            2: setting = CFG_W'(DEF_MAX_MACHINES + 1);
            3: setting = '0;
            4: setting = CFG_W'(1);
            5: setting = CFG_W'(2);
            default: setting = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 63)) :
                                                            CFG_W'($urandom_range(1, 6));
         endcase
         write_machines(setting);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            case ($urandom_range(0, 9))
               0, 1: proc = '0;
               2: proc = '1;
               3, 4: proc = PROC_W'($urandom_range(1, 15));
               default: proc = PROC_W'($urandom_range(0, 65535));
            endcase
            send_operation(proc, $urandom_range(0, 3) == 0);
         end
         drain();
      end

      // run one long sequence of full-length operations on a single machine, then a short one
      write_machines(CFG_W'(1));
      for (int n = 0; n < LONG_SEQ_ITEMS; n++)
         send_operation('1, 1'b0);
      send_operation('1, 1'b1);
      send_operation(PROC_W'(9), 1'b1);
      drain();

      if (jobs.errors == 0 && jobs.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
